// ===== hdl/cms_pkg.sv =====
// ----------------------------------------------------------------------------
// cms_pkg: shared types and constants for column mean and std deviation
// Field widths, status codes, controller states and the request/response
// bundles between the top level and the iterative calculation unit.
// ----------------------------------------------------------------------------
package cms_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int SUM_W      = 33;
	localparam int SQ_W       = 47;
	localparam int CNT_W      = 17;
	localparam int MAX_DIMS   = 16;
	localparam int DIM_W      = 4;
	localparam int DIMS_CFG_W = 5;
	localparam int MAX_POINTS = 65536;
	localparam int MEAN_W     = 24;
	localparam int SD_W       = 23;
	localparam int STAT_W     = 2;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_DROPPED = 2'd2;

	typedef enum logic [1:0] {
		TOP_ACCUM,
		TOP_LOAD,
		TOP_BUSY,
		TOP_EMIT
	} top_state_t;

	typedef enum logic [3:0] {
		C_IDLE,
		C_MUL_N2,
		C_MUL_NS2,
		C_MUL_SQ,
		C_DIFF,
		C_DIV_VAR,
		C_SQRT,
		C_DIV_MEAN,
		C_DONE
	} calc_state_t;

	typedef struct packed {
		logic                    start;
		logic signed [SUM_W-1:0] sum;
		logic [SQ_W-1:0]         sq_sum;
		logic [CNT_W-1:0]        count;
	} calc_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [MEAN_W-1:0] mean;
		logic [SD_W-1:0]          sd;
	} calc_rsp_t;

endpackage

// ===== hdl/cms_in_if.sv =====
// ----------------------------------------------------------------------------
// cms_in_if: sample input channel
// One beat carries one coordinate and the end-of-data-set mark.
// ----------------------------------------------------------------------------
interface cms_in_if;
	import cms_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic                       last_sample;

	modport source(output valid, sample_value, last_sample, input ready);
	modport sink(input valid, sample_value, last_sample, output ready);
endinterface

// ===== hdl/cms_out_if.sv =====
// ----------------------------------------------------------------------------
// cms_out_if: result output channel
// One beat carries the statistics of one dimension.
// ----------------------------------------------------------------------------
interface cms_out_if;
	import cms_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [DIM_W-1:0]         dim_index;
	logic signed [MEAN_W-1:0] mean_value;
	logic [SD_W-1:0]          std_dev;
	logic [STAT_W-1:0]        status;
	logic                     last_result;

	modport source(output valid, dim_index, mean_value, std_dev, status, last_result,
		input ready);
	modport sink(input valid, dim_index, mean_value, std_dev, status, last_result,
		output ready);
endinterface

// ===== hdl/cms_cfg_if.sv =====
// ----------------------------------------------------------------------------
// cms_cfg_if: configuration write channel
// One beat writes the dimension count register.
// ----------------------------------------------------------------------------
interface cms_cfg_if;
	import cms_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [DIMS_CFG_W-1:0] dims_in_use;

	modport source(output valid, dims_in_use, input ready);
	modport sink(input valid, dims_in_use, output ready);
endinterface

// ===== hdl/cms_store.sv =====
// ----------------------------------------------------------------------------
// cms_store: per-dimension accumulators
// Count, sum and sum of squares per dimension with one read-modify-write
// port. Entries with a clear valid bit read as zero.
// ----------------------------------------------------------------------------
module cms_store (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                acc_en,
	input  logic signed [cms_pkg::SAMPLE_W-1:0] sample,
	input  logic [cms_pkg::DIM_W-1:0]           addr,
	input  logic                                clear,
	output logic [cms_pkg::CNT_W-1:0]           rd_count,
	output logic signed [cms_pkg::SUM_W-1:0]    rd_sum,
	output logic [cms_pkg::SQ_W-1:0]            rd_sq,
	output logic                                rd_drop
);
	import cms_pkg::*;

	logic [CNT_W-1:0]        count_q [MAX_DIMS];
	logic signed [SUM_W-1:0] sum_q   [MAX_DIMS];
	logic [SQ_W-1:0]         sq_q    [MAX_DIMS];
	logic [MAX_DIMS-1:0]     valid_q;
	logic [MAX_DIMS-1:0]     drop_q;
	logic signed [2*SAMPLE_W-1:0] prod;
	logic                    full;

	// read the addressed entry, unwritten entries as zero
	assign rd_count = valid_q[addr] ? count_q[addr] : '0;
	assign rd_sum   = valid_q[addr] ? sum_q[addr] : '0;
	assign rd_sq    = valid_q[addr] ? sq_q[addr] : '0;
	assign rd_drop  = drop_q[addr];

	assign prod = sample * sample;
	assign full = rd_count >= CNT_W'(MAX_POINTS);

	// track written entries and dropped samples
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			drop_q  <= '0;
		end else if (clear) begin
			valid_q <= '0;
			drop_q  <= '0;
		end else if (acc_en) begin
			valid_q[addr] <= 1'b1;
			if (full) begin
				drop_q[addr] <= 1'b1;
			end
		end
	end

	// accumulate one sample
	always_ff @(posedge clk) begin
		if (acc_en && !full) begin
			count_q[addr] <= rd_count + CNT_W'(1);
			sum_q[addr]   <= rd_sum + SUM_W'(sample);
			sq_q[addr]    <= rd_sq + SQ_W'(unsigned'(prod));
		end
	end

endmodule

// ===== hdl/cms_calc.sv =====
// ----------------------------------------------------------------------------
// cms_calc: iterative mean and standard deviation unit
// One 64-bit add/subtract unit serves shift-add multiplies, restoring
// divides and a digit-by-digit square root under a small sequencer.
// ----------------------------------------------------------------------------
module cms_calc (
	input  logic               clk,
	input  logic               arst_n,
	input  cms_pkg::calc_req_t req,
	output cms_pkg::calc_rsp_t rsp
);
	import cms_pkg::*;

	calc_state_t state_q, state_d;

	logic [CNT_W-1:0]  n_q;
	logic [SQ_W-1:0]   s2_q;
	logic [31:0]       a_q;
	logic              neg_q;
	logic [63:0]       mc_q;
	logic [32:0]       mp_q;
	logic [63:0]       acc_q;
	logic [32:0]       n2_q;
	logic [63:0]       ns2_q;
	logic [79:0]       dvd_q;
	logic [63:0]       rem_q;
	logic [47:0]       quo_q;
	logic [23:0]       root_q;
	logic [6:0]        step_q;
	logic signed [MEAN_W-1:0] mean_q;
	logic [SD_W-1:0]   sd_q;

	logic [63:0] add_a, add_b;
	logic        add_sub;
	logic [64:0] add_res;
	logic        last;
	logic [63:0] div_sh, sq_sh, trial;
	logic [63:0] mul_nxt, rem_div_nxt, rem_sq_nxt;
	logic [47:0] quo_nxt;
	logic [23:0] root_nxt;
	logic [SUM_W-1:0] sum_abs;
	logic [MEAN_W-1:0] mean_mag;

	assign last    = step_q == 7'd1;
	assign div_sh  = {rem_q[62:0], dvd_q[79]};
	assign sq_sh   = {rem_q[61:0], dvd_q[79:78]};
	assign trial   = {38'b0, root_q, 2'b01};
	assign sum_abs = req.sum[SUM_W-1] ? SUM_W'(-req.sum) : SUM_W'(req.sum);

	// shared adder; carry out on subtract means no borrow
	assign add_res = {1'b0, add_a} + {1'b0, add_sub ? ~add_b : add_b} + 65'(add_sub);

	assign mul_nxt     = mp_q[0] ? add_res[63:0] : acc_q;
	assign rem_div_nxt = add_res[64] ? add_res[63:0] : div_sh;
	assign quo_nxt     = {quo_q[46:0], add_res[64]};
	assign rem_sq_nxt  = add_res[64] ? add_res[63:0] : sq_sh;
	assign root_nxt    = {root_q[22:0], add_res[64]};
	assign mean_mag    = quo_nxt[MEAN_W-1:0] + MEAN_W'(rem_div_nxt != 64'd0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			C_IDLE:     if (req.start) state_d = C_MUL_N2;
			C_MUL_N2:   if (last) state_d = C_MUL_NS2;
			C_MUL_NS2:  if (last) state_d = C_MUL_SQ;
			C_MUL_SQ:   if (last) state_d = C_DIFF;
			C_DIFF:     state_d = C_DIV_VAR;
			C_DIV_VAR:  if (last) state_d = C_SQRT;
			C_SQRT:     if (last) state_d = C_DIV_MEAN;
			C_DIV_MEAN: if (last) state_d = C_DONE;
			C_DONE:     state_d = C_IDLE;
			default:    state_d = C_IDLE;
		endcase
	end

	// adder operand selection
	always_comb begin
		add_a   = acc_q;
		add_b   = mc_q;
		add_sub = 1'b0;
		case (state_q)
			C_DIFF: begin
				add_a   = ns2_q;
				add_b   = acc_q;
				add_sub = 1'b1;
			end
			C_DIV_VAR: begin
				add_a   = div_sh;
				add_b   = 64'(n2_q);
				add_sub = 1'b1;
			end
			C_DIV_MEAN: begin
				add_a   = div_sh;
				add_b   = 64'(n_q);
				add_sub = 1'b1;
			end
			C_SQRT: begin
				add_a   = sq_sh;
				add_b   = trial;
				add_sub = 1'b1;
			end
			default: begin
				add_a   = acc_q;
				add_b   = mc_q;
				add_sub = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (req.start) begin
					n_q    <= req.count;
					s2_q   <= req.sq_sum;
					neg_q  <= req.sum[SUM_W-1];
					a_q    <= sum_abs[31:0];
					mc_q   <= 64'(req.count);
					mp_q   <= 33'(req.count);
					acc_q  <= '0;
					step_q <= 7'd17;
				end
			end
			C_MUL_N2, C_MUL_NS2, C_MUL_SQ: begin
				acc_q  <= mul_nxt;
				mc_q   <= {mc_q[62:0], 1'b0};
				mp_q   <= {1'b0, mp_q[32:1]};
				step_q <= step_q - 7'd1;
				if (last && state_q == C_MUL_N2) begin
					n2_q   <= mul_nxt[32:0];
					mc_q   <= 64'(s2_q);
					mp_q   <= 33'(n_q);
					acc_q  <= '0;
					step_q <= 7'd17;
				end
				if (last && state_q == C_MUL_NS2) begin
					ns2_q  <= mul_nxt;
					mc_q   <= 64'(a_q);
					mp_q   <= 33'(a_q);
					acc_q  <= '0;
					step_q <= 7'd32;
				end
			end
			C_DIFF: begin
				dvd_q  <= {(add_res[64] ? add_res[63:0] : 64'd0), 16'd0};
				rem_q  <= '0;
				quo_q  <= '0;
				step_q <= 7'd80;
			end
			C_DIV_VAR: begin
				rem_q  <= rem_div_nxt;
				quo_q  <= quo_nxt;
				dvd_q  <= {dvd_q[78:0], 1'b0};
				step_q <= step_q - 7'd1;
				if (last) begin
					dvd_q  <= {quo_nxt, 32'd0};
					rem_q  <= '0;
					root_q <= '0;
					step_q <= 7'd24;
				end
			end
			C_SQRT: begin
				rem_q  <= rem_sq_nxt;
				root_q <= root_nxt;
				dvd_q  <= {dvd_q[77:0], 2'b00};
				step_q <= step_q - 7'd1;
				if (last) begin
					sd_q   <= (root_nxt == 24'd0) ? SD_W'(1) : root_nxt[SD_W-1:0];
					dvd_q  <= {a_q, 8'd0, 40'd0};
					rem_q  <= '0;
					quo_q  <= '0;
					step_q <= 7'd40;
				end
			end
			C_DIV_MEAN: begin
				rem_q  <= rem_div_nxt;
				quo_q  <= quo_nxt;
				dvd_q  <= {dvd_q[78:0], 1'b0};
				step_q <= step_q - 7'd1;
				if (last) begin
					mean_q <= neg_q ? -signed'(mean_mag) : signed'(quo_nxt[MEAN_W-1:0]);
				end
			end
			default: begin
				step_q <= step_q;
			end
		endcase
	end

	assign rsp.done = state_q == C_DONE;
	assign rsp.mean = mean_q;
	assign rsp.sd   = sd_q;

endmodule

// ===== hdl/column_mean_and_std_dev.sv =====
// ----------------------------------------------------------------------------
// column_mean_and_std_dev: per-dimension mean and population std deviation
// Accumulates a stream of samples per dimension and reports Q.8 statistics
// for every dimension in use when the data set ends.
// ----------------------------------------------------------------------------
// Usage:
//   cfg     : write dims_in_use (0 acts as 1, above 16 acts as 16) while idle.
//   samples : one coordinate per beat, dimension cycling 0..dims-1. Each beat
//             is accumulated in the cycle it is taken, so samples stream at
//             one per cycle.
//   results : after a beat marked last_sample, samples.ready drops and one
//             result per dimension leaves in order, last_result on the last.
//   Each dimension with samples runs through the shared add/subtract unit
//   in order: multiplies n*n, n*sq_sum and sum*sum, the difference, the
//   variance divide, the root and the mean divide; an empty one skips it.
//   Results sit in an output register; a stalled receiver holds the block
//   after the next result is ready. After the last result the stores clear
//   at once and samples.ready returns.
//   Reset clears all stores and the dimension cursor and sets dims to 1.
// ----------------------------------------------------------------------------
module column_mean_and_std_dev (
	input logic         clk,
	input logic         arst_n,
	cms_cfg_if.sink     cfg,
	cms_in_if.sink      samples,
	cms_out_if.source   results
);
	import cms_pkg::*;

	top_state_t state_q, state_d;

	logic [DIMS_CFG_W-1:0] dims_cfg_q;
	logic [DIM_W-1:0]      dims_m1;
	logic [DIM_W-1:0]      cursor_q;
	logic [DIM_W-1:0]      cur_eff;
	logic [DIM_W-1:0]      dim_q;
	logic [DIM_W-1:0]      addr;

	logic                  acc_en;
	logic                  clear;
	logic                  out_free;
	logic                  emit_fire;
	logic                  dim_last;

	logic [CNT_W-1:0]        rd_count;
	logic signed [SUM_W-1:0] rd_sum;
	logic [SQ_W-1:0]         rd_sq;
	logic                    rd_drop;

	calc_req_t req;
	calc_rsp_t rsp;

	logic signed [MEAN_W-1:0] res_mean_q;
	logic [SD_W-1:0]          res_sd_q;
	logic [STAT_W-1:0]        res_stat_q;
	logic                     out_valid_q;

	// clamp the dimension count
	always_comb begin
		if (dims_cfg_q == '0) begin
			dims_m1 = '0;
		end else if (dims_cfg_q > DIMS_CFG_W'(MAX_DIMS)) begin
			dims_m1 = DIM_W'(MAX_DIMS - 1);
		end else begin
			dims_m1 = DIM_W'(dims_cfg_q - DIMS_CFG_W'(1));
		end
	end

	assign cur_eff  = (cursor_q > dims_m1) ? '0 : cursor_q;
	assign dim_last = dim_q == dims_m1;
	assign out_free = !out_valid_q || results.ready;
	assign addr     = (state_q == TOP_ACCUM) ? cur_eff : dim_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			TOP_ACCUM: if (samples.valid && samples.last_sample) state_d = TOP_LOAD;
			TOP_LOAD:  state_d = (rd_count == '0) ? TOP_EMIT : TOP_BUSY;
			TOP_BUSY:  if (rsp.done) state_d = TOP_EMIT;
			TOP_EMIT:  if (out_free) state_d = dim_last ? TOP_ACCUM : TOP_LOAD;
			default:   state_d = TOP_ACCUM;
		endcase
	end

	// control outputs
	always_comb begin
		samples.ready = state_q == TOP_ACCUM;
		acc_en        = state_q == TOP_ACCUM && samples.valid;
		emit_fire     = state_q == TOP_EMIT && out_free;
		clear         = emit_fire && dim_last;
		req.start     = state_q == TOP_LOAD && rd_count != '0;
		req.sum       = rd_sum;
		req.sq_sum    = rd_sq;
		req.count     = rd_count;
	end

	assign cfg.ready = 1'b1;

	cms_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc_en   (acc_en),
		.sample   (samples.sample_value),
		.addr     (addr),
		.clear    (clear),
		.rd_count (rd_count),
		.rd_sum   (rd_sum),
		.rd_sq    (rd_sq),
		.rd_drop  (rd_drop)
	);

	cms_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= TOP_ACCUM;
			dims_cfg_q  <= DIMS_CFG_W'(1);
			cursor_q    <= '0;
			dim_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				dims_cfg_q <= cfg.dims_in_use;
			end
			// advance the cursor on each sample beat
			if (acc_en) begin
				cursor_q <= (cur_eff == dims_m1) ? '0 : cur_eff + DIM_W'(1);
			end
			if (clear) begin
				cursor_q <= '0;
			end
			if (state_q == TOP_ACCUM) begin
				dim_q <= '0;
			end else if (emit_fire && !dim_last) begin
				dim_q <= dim_q + DIM_W'(1);
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold per-dimension results until emitted
	always_ff @(posedge clk) begin
		if (state_q == TOP_LOAD && rd_count == '0) begin
			res_mean_q <= '0;
			res_sd_q   <= SD_W'(1);
			res_stat_q <= STAT_EMPTY;
		end else if (state_q == TOP_LOAD) begin
			res_stat_q <= rd_drop ? STAT_DROPPED : STAT_OK;
		end else if (state_q == TOP_BUSY && rsp.done) begin
			res_mean_q <= rsp.mean;
			res_sd_q   <= rsp.sd;
		end
		if (emit_fire) begin
			results.dim_index   <= dim_q;
			results.mean_value  <= res_mean_q;
			results.std_dev     <= res_sd_q;
			results.status      <= res_stat_q;
			results.last_result <= dim_last;
		end
	end

	assign results.valid = out_valid_q;

`ifndef SYNTHESIS
	a_last_stops_input: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready && samples.last_sample |=> !samples.ready)
		else $error("input still ready after last sample beat");

	a_last_result_dim: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.last_result |-> results.dim_index == dims_m1)
		else $error("last result on wrong dimension");

	a_sd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.std_dev != '0)
		else $error("std deviation below floor");

	a_done_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> state_q == TOP_BUSY)
		else $error("calculation finished outside busy state");
`endif

endmodule

// ===== dv/column_mean_and_std_dev_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// column_mean_and_std_dev_tb: self-checking bench for the column statistics
// Streams signed samples through the sample channel, rewrites the dimension
// count between data sets, and compares every result beat field by field
// with an in-bench integer model of mean and population deviation.
// Both sides idle at random; one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module column_mean_and_std_dev_tb;
	import cms_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	typedef struct {
		logic [DIM_W-1:0]         dim;
		logic signed [MEAN_W-1:0] mean;
		logic [SD_W-1:0]          sd;
		logic [STAT_W-1:0]        stat;
		logic                     lastr;
	} stat_beat_t;

	typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		int                value;
		bit                last;
		bit                typed;
		int                e_mean;
		int                e_sd;
		logic [STAT_W-1:0] e_stat;
	} stim_row_t;

	logic clk;
	logic arst_n;

	cms_cfg_if cfg();
	cms_in_if  samples();
	cms_out_if results();

	column_mean_and_std_dev dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.samples(samples),
		.results(results)
	);

	// model state
	logic [DIMS_CFG_W-1:0] m_dims_reg;
	longint                m_sum[MAX_DIMS];
	longint unsigned       m_sq[MAX_DIMS];
	longint unsigned       m_cnt[MAX_DIMS];
	bit                    m_drop[MAX_DIMS];
	int                    m_cursor;

	stat_beat_t stat_q[$];
	int         errors;
	int         idle_cycles;
	bit         no_gaps;
	bit         hold_now;

	always #5 clk = ~clk;

	function automatic int dims_active();
		if (m_dims_reg == 0) return 1;
		if (m_dims_reg > MAX_DIMS) return MAX_DIMS;
		return int'(m_dims_reg);
	endfunction

	function automatic void clear_sums();
		for (int i = 0; i < MAX_DIMS; i++) begin
			m_sum[i] = 0;
			m_sq[i] = 0;
			m_cnt[i] = 0;
			m_drop[i] = 0;
		end
		m_cursor = 0;
	endfunction

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint mean_q8(longint s1, longint n);
		longint num;
		num = s1 * 256;
		if (num >= 0) return num / n;
		return -((-num + n - 1) / n);
	endfunction

	function automatic longint unsigned sd_q8(longint s1, longint unsigned s2,
		longint unsigned n);
		longint unsigned a, ns2, sq, m, n2, q, r;
		a = (s1 < 0) ? longint'(-s1) : longint'(s1);
		ns2 = n * s2;
		sq = a * a;
		m = (ns2 > sq) ? ns2 - sq : 0;
		n2 = n * n;
		q = m / n2;
		r = m % n2;
		// long division for the 16 fractional bits of the variance
		for (int i = 0; i < 16; i++) begin
			r <<= 1;
			q <<= 1;
			if (r >= n2) begin
				r -= n2;
				q |= 1;
			end
		end
		q = isqrt(q);
		return (q < 1) ? 1 : q;
	endfunction

	// accumulate one accepted sample; queue the statistics on the last one
	function automatic void stats_accumulate(logic signed [SAMPLE_W-1:0] x, bit last);
		int         nd;
		int         d;
		longint     xv;
		stat_beat_t b;
		nd = dims_active();
		xv = x;
		if (m_cursor >= nd) m_cursor = 0;
		d = m_cursor;
		if (m_cnt[d] >= MAX_POINTS) begin
			m_drop[d] = 1;
		end else begin
			m_cnt[d] += 1;
			m_sum[d] += xv;
			m_sq[d] += longint'(xv * xv);
		end
		m_cursor = (d + 1 >= nd) ? 0 : d + 1;
		if (!last) return;
		for (int k = 0; k < nd; k++) begin
			b.dim = DIM_W'(k);
			b.lastr = (k == nd - 1);
			if (m_cnt[k] == 0) begin
				b.mean = '0;
				b.sd = SD_W'(1);
				b.stat = STAT_EMPTY;
			end else begin
				b.mean = MEAN_W'(mean_q8(m_sum[k], m_cnt[k]));
				b.sd = SD_W'(sd_q8(m_sum[k], m_sq[k], m_cnt[k]));
				b.stat = m_drop[k] ? STAT_DROPPED : STAT_OK;
			end
			stat_q.push_back(b);
		end
		clear_sums();
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_sample(logic signed [SAMPLE_W-1:0] x, bit last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			samples.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.sample_value <= x;
		samples.last_sample <= last;
		do @(posedge clk); while (!samples.ready);
		stats_accumulate(x, last);
	endtask

	// write the dimension count once all pending statistics are out
	task automatic write_dims(logic [DIMS_CFG_W-1:0] v);
		samples.valid <= 1'b0;
		wait (stat_q.size() == 0);
		repeat (10) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.dims_in_use <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		m_dims_reg = v;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'sh7FFF;
		if (r == 1) return 16'sh8000;
		if (r < 5) return SAMPLE_W'(int'($urandom_range(0, 200)) - 100);
		return SAMPLE_W'($urandom());
	endfunction

	// result checker
	always @(posedge clk) begin
		stat_beat_t e;
		if (arst_n && results.valid && results.ready) begin
			if (stat_q.size() == 0) begin
				$error("unexpected result beat for dim %0d", results.dim_index);
				errors++;
			end else begin
				e = stat_q.pop_front();
				if (results.dim_index !== e.dim) begin
					$error("dim_index exp %0d got %0d", e.dim, results.dim_index);
					errors++;
				end
				if (results.mean_value !== e.mean) begin
					$error("mean_value exp %0d got %0d", e.mean, results.mean_value);
					errors++;
				end
				if (results.std_dev !== e.sd) begin
					$error("std_dev exp %0d got %0d", e.sd, results.std_dev);
					errors++;
				end
				if (results.status !== e.stat) begin
					$error("status exp %0d got %0d", e.stat, results.status);
					errors++;
				end
				if (results.last_result !== e.lastr) begin
					$error("last_result exp %0d got %0d", e.lastr, results.last_result);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((samples.valid && samples.ready) || (results.valid && results.ready)
			|| (cfg.valid && cfg.ready) || !arst_n) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver: short and long stalls, plus one long hold-off on request
	initial begin
		int r;
		results.ready = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_now) begin
				results.ready <= 1'b0;
				repeat (2000) @(posedge clk);
				hold_now = 0;
			end else begin
				r = $urandom_range(0, 99);
				if (no_gaps || r < 60) begin
					results.ready <= 1'b1;
					repeat ($urandom_range(1, 20)) @(posedge clk);
				end else if (r < 95) begin
					results.ready <= 1'b0;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end else begin
					results.ready <= 1'b0;
					repeat ($urandom_range(20, 200)) @(posedge clk);
				end
			end
		end
	end

	stim_row_t dir_rows[] = '{
		'{ROW_SAMPLE, 32767, 1, 1, 8388352, 1, STAT_OK},
		'{ROW_SAMPLE, -32768, 1, 1, -8388608, 1, STAT_OK},
		'{ROW_CFG, 0, 0, 0, 0, 0, STAT_OK},
		'{ROW_SAMPLE, 0, 1, 1, 0, 1, STAT_OK},
		'{ROW_CFG, 4, 0, 0, 0, 0, STAT_OK},
		'{ROW_SAMPLE, 100, 1, 1, 25600, 1, STAT_OK},
		'{ROW_CFG, 16, 0, 0, 0, 0, STAT_OK},
		'{ROW_SAMPLE, -32768, 0, 0, 0, 0, STAT_OK},
		'{ROW_SAMPLE, 32767, 0, 0, 0, 0, STAT_OK},
		'{ROW_SAMPLE, -1, 0, 0, 0, 0, STAT_OK},
		'{ROW_SAMPLE, 1, 1, 0, 0, 0, STAT_OK},
		'{ROW_CFG, 31, 0, 0, 0, 0, STAT_OK},
		'{ROW_SAMPLE, 12345, 0, 0, 0, 0, STAT_OK},
		'{ROW_SAMPLE, -23456, 1, 0, 0, 0, STAT_OK},
		'{ROW_CFG, 5, 0, 0, 0, 0, STAT_OK},
		'{ROW_SAMPLE, 3, 0, 0, 0, 0, STAT_OK},
		'{ROW_SAMPLE, -5, 0, 0, 0, 0, STAT_OK},
		'{ROW_SAMPLE, 300, 0, 0, 0, 0, STAT_OK},
		'{ROW_CFG, 2, 0, 0, 0, 0, STAT_OK},
		'{ROW_SAMPLE, 7, 0, 0, 0, 0, STAT_OK},
		'{ROW_SAMPLE, -7, 0, 0, 0, 0, STAT_OK},
		'{ROW_SAMPLE, 9, 1, 0, 0, 0, STAT_OK}
	};

	initial begin
		int nd;
		int pts;
		int base;
		logic [DIMS_CFG_W-1:0] phase_dims[6];
		clk = 1'b0;
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.dims_in_use = '0;
		samples.valid = 1'b0;
		samples.sample_value = '0;
		samples.last_sample = 1'b0;
		errors = 0;
		idle_cycles = 0;
		no_gaps = 0;
		hold_now = 0;
		m_dims_reg = 1;
		clear_sums();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; typed rows overwrite dim 0 of the queued statistics
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				write_dims(DIMS_CFG_W'(dir_rows[i].value));
			end else begin
				send_sample(SAMPLE_W'(dir_rows[i].value), dir_rows[i].last);
				if (dir_rows[i].typed) begin
					base = stat_q.size() - dims_active();
					stat_q[base].mean = MEAN_W'(dir_rows[i].e_mean);
					stat_q[base].sd = SD_W'(dir_rows[i].e_sd);
					stat_q[base].stat = dir_rows[i].e_stat;
				end
			end
		end

		// short single-dimension burst at full rate
		write_dims(1);
		no_gaps = 1;
		for (int i = 0; i < 8; i++)
			send_sample(rand_sample(), i == 7);
		no_gaps = 0;

		// random phases, mostly whole points with random content
		phase_dims = '{3, 16, 1, 0, 31, 0};
		phase_dims[5] = DIMS_CFG_W'($urandom_range(1, 15));
		for (int p = 0; p < 6; p++) begin
			write_dims(phase_dims[p]);
			nd = dims_active();
			if (p == 0) hold_now = 1;
			for (int s = 0; s < 3; s++) begin
				if ($urandom_range(0, 3) == 0)
					pts = $urandom_range(1, 3 * nd);
				else
					pts = nd * $urandom_range(1, 3);
				if (nd * 3 > 30 && pts > 16) pts = $urandom_range(nd, 16);
				for (int k = 0; k < pts; k++)
					send_sample(rand_sample(), k == pts - 1);
			end
		end
		samples.valid <= 1'b0;

		wait (stat_q.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
